[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked on the rising
// edge of clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/stp_pkg.sv]
package stp_pkg;

   localparam int VALUE_BITS = 64;
   localparam int COUNT_BITS = 16;
   localparam int RADIX_W    = 6;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 7;
   localparam int RESULT_W   = 64;
   localparam int STATUS_W   = 2;
   localparam int CHARS_W    = 16;
   localparam int PROD_W     = VALUE_BITS + RADIX_W;
   localparam int SUM_W      = VALUE_BITS + RADIX_W + 1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RADIX = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_AUTO    = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_INVALID = 6'd1;
   localparam logic [RADIX_W-1:0] RADIX_BIN     = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_OCT     = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC     = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX     = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_TOP     = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET   = RADIX_DEC;

   localparam logic [DIGIT_W-1:0] NO_DIGIT = 7'd99;

   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_B = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

   // Magnitude of the most negative value; also its bit pattern.
   localparam logic [VALUE_BITS-1:0] MAG_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [RESULT_W-1:0] RESULT_MAX = RESULT_W'(VALUE_MAX);
   localparam logic signed [RESULT_W-1:0] RESULT_MIN = RESULT_W'(VALUE_MIN);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [CHAR_W-1:0] char_byte;
      logic              starts_string;
   } req_word_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] parsed_value;
      logic [STATUS_W-1:0]        status;
      logic [CHARS_W-1:0]         chars_consumed;
   } rsp_word_type;

   // Value of a character as a digit (0 to 35), or NO_DIGIT.
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] d;
      d = NO_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = DIGIT_W'(c - CH_ZERO);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         d = DIGIT_W'(c - CH_LOWER_A) + 7'd10;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         d = DIGIT_W'(c - CH_UPPER_A) + 7'd10;
      end
      return d;
   endfunction

endpackage

[rtl/stp_in_reg.sv]
module stp_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stp_pkg::req_word_type req_word,
   input  logic                 advance,
   output logic                 held_valid,
   output stp_pkg::req_word_type held_word
);
   import stp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         take;

   // The register frees up in the same cycle that its word moves on.
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         word_ff <= req_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

[rtl/stp_core.sv]
module stp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [5:0]            csr_data,
   input  logic                  step,
   input  stp_pkg::req_word_type item,
   output logic                  res_valid,
   output stp_pkg::rsp_word_type res_word
);
   import stp_pkg::*;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_PREFIX,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   logic [RADIX_W-1:0]    radix_setting_ff;
   phase_type             phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  finished_ff, finished_in;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] n);
      return (n == COUNT_MAX) ? n : n + 1'b1;
   endfunction

   always_comb begin
      logic [CHAR_W-1:0]     c;
      logic                  bad_radix;
      logic                  is_space;
      logic                  is_sign;
      logic                  at_prefix;
      logic                  at_zero;
      logic                  do_digit;
      logic [DIGIT_W-1:0]    dig;
      logic [PROD_W-1:0]     prod;
      logic [SUM_W-1:0]      sum;
      logic [VALUE_BITS-1:0] val;
      logic [STATUS_W-1:0]   st;

      c         = item.char_byte;
      bad_radix = (radix_setting_ff == RADIX_INVALID) || (radix_setting_ff > RADIX_TOP);
      is_space  = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
      is_sign   = (c == CH_MINUS) || (c == CH_PLUS);
      at_prefix = 1'b0;
      at_zero   = 1'b0;
      do_digit  = 1'b0;
      dig       = digit_of(c);
      prod      = '0;
      sum       = '0;
      val       = '0;
      st        = STATUS_OK;

      phase_in    = phase_ff;
      neg_in      = neg_ff;
      radix_in    = radix_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      res_valid   = 1'b0;
      res_word    = '0;

      if (step) begin
         if (item.starts_string) begin
            phase_in    = PH_SPACE;
            neg_in      = 1'b0;
            acc_in      = '0;
            ovf_in      = 1'b0;
            count_in    = '0;
            radix_in    = radix_setting_ff;
            finished_in = bad_radix;
         end
         if (item.starts_string && bad_radix) begin
            res_valid       = 1'b1;
            res_word.status = STATUS_BAD_RADIX;
         end else if (!finished_in) begin
            case (phase_in)
               PH_SPACE: begin
                  if (is_space) begin
                     count_in = sat_inc(count_in);
                  end else if (is_sign) begin
                     neg_in   = (c == CH_MINUS);
                     count_in = sat_inc(count_in);
                     phase_in = PH_PREFIX;
                  end else begin
                     at_prefix = 1'b1;
                  end
               end
               PH_PREFIX: at_prefix = 1'b1;
               PH_ZERO:   at_zero = 1'b1;
               default:   do_digit = 1'b1;
            endcase

            if (at_prefix) begin
               if (c == CH_ZERO && (radix_in == RADIX_AUTO || radix_in == RADIX_HEX ||
                                    radix_in == RADIX_BIN)) begin
                  count_in = sat_inc(count_in);
                  phase_in = PH_ZERO;
               end else begin
                  radix_in = (radix_in == RADIX_AUTO) ? RADIX_DEC : radix_in;
                  phase_in = PH_DIGITS;
                  do_digit = 1'b1;
               end
            end

            if (at_zero) begin
               if ((radix_in == RADIX_AUTO || radix_in == RADIX_HEX) &&
                   (c == CH_LOWER_X || c == CH_UPPER_X)) begin
                  radix_in = RADIX_HEX;
                  count_in = sat_inc(count_in);
                  phase_in = PH_DIGITS;
               end else if ((radix_in == RADIX_AUTO || radix_in == RADIX_BIN) &&
                            (c == CH_LOWER_B || c == CH_UPPER_B)) begin
                  radix_in = RADIX_BIN;
                  count_in = sat_inc(count_in);
                  phase_in = PH_DIGITS;
               end else begin
                  // The leading zero was itself a digit of value zero.
                  radix_in = (radix_in == RADIX_AUTO) ? RADIX_OCT : radix_in;
                  phase_in = PH_DIGITS;
                  do_digit = 1'b1;
               end
            end

            if (do_digit) begin
               if (dig >= {1'b0, radix_in} || radix_in < RADIX_BIN) begin
                  if (neg_in) begin
                     val = ovf_in ? VALUE_MIN : ('0 - acc_in);
                     st  = ovf_in ? STATUS_RANGE : STATUS_OK;
                  end else if (ovf_in || acc_in == MAG_LIMIT) begin
                     val = VALUE_MAX;
                     st  = STATUS_RANGE;
                  end else begin
                     val = acc_in;
                  end
                  res_valid               = 1'b1;
                  res_word.parsed_value   = RESULT_W'(signed'(val));
                  res_word.status         = st;
                  res_word.chars_consumed = CHARS_W'(count_in);
                  finished_in             = 1'b1;
               end else begin
                  // Overflow is exact: the new magnitude may reach the limit but not pass it.
                  prod = PROD_W'(acc_in) * PROD_W'(radix_in);
                  sum  = SUM_W'(prod) + SUM_W'(dig);
                  if (!ovf_in) begin
                     if (sum > SUM_W'(MAG_LIMIT)) begin
                        ovf_in = 1'b1;
                     end else begin
                        acc_in = sum[VALUE_BITS-1:0];
                     end
                  end
                  count_in = sat_inc(count_in);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_setting_ff <= RADIX_RESET;
         phase_ff         <= PH_SPACE;
         neg_ff           <= 1'b0;
         radix_ff         <= RADIX_AUTO;
         ovf_ff           <= 1'b0;
         count_ff         <= '0;
         finished_ff      <= 1'b1;
      end else begin
         if (csr_write) begin
            radix_setting_ff <= csr_data;
         end
         phase_ff    <= phase_in;
         neg_ff      <= neg_in;
         radix_ff    <= radix_in;
         ovf_ff      <= ovf_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
      end
      acc_ff <= acc_in;
   end

endmodule

[rtl/stp_out_reg.sv]
module stp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stp_pkg::rsp_word_type push_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output stp_pkg::rsp_word_type rsp_word
);
   import stp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // A push only happens when the register is empty or its word is being taken.
   assign valid_in = push || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push) begin
         word_ff <= push_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

[rtl/string_to_integer_parser.sv]
// Streaming strtol-style parser: one character word is accepted per clock cycle
// while the output side does not stall, and a result word appears once the character
// that ends the number has passed the input register, then the parse step into the
// output register. The one-per-cycle rate is set by the accumulator update, a multiply
// by the radix plus the digit and the exact overflow compare, all combinational. The
// radix register is sampled when a word with starts_string set is parsed, so write
// it only while the block is idle; an invalid radix gives a status 2 result at once.
`include "assert_macros.svh"

module string_to_integer_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  stp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output stp_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [5:0]            csr_data
);
   import stp_pkg::*;

   logic         held_valid;
   req_word_type held_word;
   logic         advance;
   logic         res_valid;
   rsp_word_type res_word;

   assign csr_ready = 1'b1;

   // The parse step runs whenever a word is held and the output register can take its result.
   assign advance = held_valid && (!rsp_valid || !rsp_stall);

   stp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (advance),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   stp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .step      (advance),
      .item      (held_word),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   stp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   `ASSERT_IMPLY(a_bad_radix_empty, rsp_valid && rsp_word.status == STATUS_BAD_RADIX, rsp_word.parsed_value == '0 && rsp_word.chars_consumed == '0, "invalid radix result carries a value or count")
   `ASSERT_IMPLY(a_range_saturates, rsp_valid && rsp_word.status == STATUS_RANGE, rsp_word.parsed_value == RESULT_MAX || rsp_word.parsed_value == RESULT_MIN, "out of range result is not saturated")
   `ASSERT_IMPLY(a_no_stall_when_empty, !rsp_valid, !req_stall, "input stalled while the output register is empty")
   `ASSERT_ALWAYS(a_status_code, rsp_word.status <= STATUS_BAD_RADIX || !rsp_valid, "result status has an undefined code")

endmodule
